FILE: design/sdlms_pkg.sv
// Shared constants, types and state encoding for the soft decision LMS equalizer.
// No dependencies; the top level, the cell and the head use it by scoped names.
package sdlms_pkg;

	localparam int TAP_COUNT  = 64;
	localparam int CENTER_TAP = 16;
	localparam int CENTER_IDX = CENTER_TAP % TAP_COUNT;
	localparam int CNT_W      = $clog2(TAP_COUNT);
	// FIR accumulator: 48-bit products summed over TAP_COUNT entries
	localparam int ACC_W      = 48 + CNT_W;
	// energy accumulator: 37-bit terms summed over TAP_COUNT entries
	localparam int EN_W       = 37 + CNT_W;

	localparam logic signed [31:0] ONE_Q27 = 32'sd134217728;
	localparam logic [EN_W-1:0] ENERGY_LIMIT = EN_W'(64'd2500 << 27);

	localparam logic [31:0] STEP_RESET = 32'd214748;
	localparam logic [15:0] GATE_RESET = 16'd4096;

	// register select, byte address bit 2
	localparam logic REG_STEP = 1'b0;
	localparam logic REG_GATE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_FIR,
		S_FDRAIN,
		S_CALC1,
		S_CALC2,
		S_CALC3,
		S_UPD,
		S_ENERGY,
		S_EDRAIN,
		S_EDEC,
		S_OUT
	} state_t;

	typedef struct packed {
		logic shift;
		logic rot;
		logic ident;
	} cell_ctrl_t;

	typedef struct packed {
		logic acc_clr;
		logic mac;
		logic calc1;
		logic calc2;
		logic calc3;
		logic upd;
		logic en_clr;
		logic sq;
	} head_ctrl_t;

endpackage

FILE: design/sdlms_if.sv
// Valid/ready channel interfaces for input samples and equalizer results.
// Stand-alone; no package needed.
interface sdlms_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_in;
	logic               is_data;
	logic               segment_end;

	modport source (output valid, sample_in, is_data, segment_end, input ready);
	modport sink   (input valid, sample_in, is_data, segment_end, output ready);
endinterface

interface sdlms_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] equalized;
	logic signed [3:0]  decision;
	logic               tap_reset;
	logic               last_of_segment;

	modport source (output valid, equalized, decision, tap_reset, last_of_segment, input ready);
	modport sink   (input valid, equalized, decision, tap_reset, last_of_segment, output ready);
endinterface

FILE: design/soft_decision_directed_lms_equalizer.sv
// An item whose centre entry is not flagged as data gives no result; a data item runs the
// FIR pass and calc steps, an update pass if the taps adapt, an energy pass on segment end.
// Items are taken one at a time, paced by the single MAC at the head of the tap ring, which
// needs one full rotation of TAP_COUNT cells per FIR, update and energy pass.
// Reset (arst_n low): window cleared, taps to identity, registers to defaults.
// Uses sdlms_pkg, sdlms_if, sdlms_cell and sdlms_head.
module soft_decision_directed_lms_equalizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	sdlms_in_if.sink           in_ch,
	sdlms_out_if.source        out_ch
);

	localparam int N  = sdlms_pkg::TAP_COUNT;
	localparam int CW = sdlms_pkg::CNT_W;

	logic [31:0] step_q;
	logic [15:0] gate_q;

	sdlms_pkg::state_t     state_q, state_d;
	sdlms_pkg::cell_ctrl_t cctrl;
	sdlms_pkg::head_ctrl_t hctrl;

	logic [CW-1:0] cnt_q;
	logic          last;
	logic          seg_q;
	logic          tapres_q;
	logic          out_go;

	logic signed [15:0] smp [N];
	logic [1:0]         flg [N];
	logic signed [31:0] tp  [N];

	logic signed [15:0] ring_sample;
	logic [1:0]         ring_flags;
	logic signed [31:0] tap_next;
	logic signed [15:0] y;
	logic signed [3:0]  level;
	logic               adapt;
	logic               over_limit;

	logic               out_valid_q;
	logic signed [15:0] eq_q;
	logic signed [3:0]  dec_q;
	logic               tr_q;
	logic               ls_q;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sdlms_pkg::STEP_RESET;
			gate_q <= sdlms_pkg::GATE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				sdlms_pkg::REG_STEP: step_q <= pwdata;
				sdlms_pkg::REG_GATE: gate_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			sdlms_pkg::REG_STEP: prdata = step_q;
			sdlms_pkg::REG_GATE: prdata = {16'd0, gate_q};
			default: prdata = '0;
		endcase
	end

	// cell ring: cell k takes from cell k+1, the last one from input or the head
	assign ring_sample = cctrl.shift ? in_ch.sample_in : smp[0];
	assign ring_flags  = cctrl.shift ? {in_ch.segment_end, in_ch.is_data} : flg[0];

	for (genvar k = 0; k < N; k++) begin : g_cell
		if (k == N - 1) begin : g_last
			sdlms_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (cctrl),
				.ident_one (k == sdlms_pkg::CENTER_IDX),
				.nb_sample (ring_sample),
				.nb_flags  (ring_flags),
				.nb_tap    (tap_next),
				.sample_q  (smp[k]),
				.flags_q   (flg[k]),
				.tap_q     (tp[k])
			);
		end else begin : g_mid
			sdlms_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (cctrl),
				.ident_one (k == sdlms_pkg::CENTER_IDX),
				.nb_sample (smp[k+1]),
				.nb_flags  (flg[k+1]),
				.nb_tap    (tp[k+1]),
				.sample_q  (smp[k]),
				.flags_q   (flg[k]),
				.tap_q     (tp[k])
			);
		end
	end

	sdlms_head u_head (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (hctrl),
		.x          (smp[0]),
		.tap        (tp[0]),
		.mu         (step_q),
		.ig         (gate_q),
		.tap_next   (tap_next),
		.y          (y),
		.level      (level),
		.adapt      (adapt),
		.over_limit (over_limit)
	);

	assign last   = cnt_q == CW'(N - 1);
	assign out_go = !out_valid_q || out_ch.ready;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdlms_pkg::S_IDLE:   if (in_ch.valid) state_d = sdlms_pkg::S_CHECK;
			sdlms_pkg::S_CHECK:  state_d = flg[sdlms_pkg::CENTER_IDX][0] ?
			                               sdlms_pkg::S_FIR : sdlms_pkg::S_IDLE;
			sdlms_pkg::S_FIR:    if (last) state_d = sdlms_pkg::S_FDRAIN;
			sdlms_pkg::S_FDRAIN: state_d = sdlms_pkg::S_CALC1;
			sdlms_pkg::S_CALC1:  state_d = sdlms_pkg::S_CALC2;
			sdlms_pkg::S_CALC2:  state_d = sdlms_pkg::S_CALC3;
			sdlms_pkg::S_CALC3: begin
				if (adapt)
					state_d = sdlms_pkg::S_UPD;
				else
					state_d = seg_q ? sdlms_pkg::S_ENERGY : sdlms_pkg::S_OUT;
			end
			sdlms_pkg::S_UPD:    if (last) state_d = seg_q ? sdlms_pkg::S_ENERGY :
			                                                 sdlms_pkg::S_OUT;
			sdlms_pkg::S_ENERGY: if (last) state_d = sdlms_pkg::S_EDRAIN;
			sdlms_pkg::S_EDRAIN: state_d = sdlms_pkg::S_EDEC;
			sdlms_pkg::S_EDEC:   state_d = sdlms_pkg::S_OUT;
			sdlms_pkg::S_OUT:    if (out_go) state_d = sdlms_pkg::S_IDLE;
			default:             state_d = sdlms_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cctrl       = '0;
		hctrl       = '0;
		in_ch.ready = 1'b0;
		unique case (state_q)
			sdlms_pkg::S_IDLE: begin
				in_ch.ready = 1'b1;
				cctrl.shift = in_ch.valid;
			end
			sdlms_pkg::S_CHECK: hctrl.acc_clr = 1'b1;
			sdlms_pkg::S_FIR: begin
				cctrl.rot = 1'b1;
				hctrl.mac = 1'b1;
			end
			sdlms_pkg::S_CALC1: begin
				hctrl.calc1  = 1'b1;
				hctrl.en_clr = 1'b1;
			end
			sdlms_pkg::S_CALC2: hctrl.calc2 = 1'b1;
			sdlms_pkg::S_CALC3: hctrl.calc3 = 1'b1;
			sdlms_pkg::S_UPD: begin
				cctrl.rot = 1'b1;
				hctrl.upd = 1'b1;
			end
			sdlms_pkg::S_ENERGY: begin
				cctrl.rot = 1'b1;
				hctrl.sq  = 1'b1;
			end
			sdlms_pkg::S_EDEC: cctrl.ident = over_limit;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sdlms_pkg::S_IDLE;
			cnt_q    <= '0;
			seg_q    <= 1'b0;
			tapres_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cctrl.rot)
				cnt_q <= last ? '0 : cnt_q + 1'b1;
			if (state_q == sdlms_pkg::S_CHECK) begin
				seg_q    <= flg[sdlms_pkg::CENTER_IDX][1];
				tapres_q <= 1'b0;
			end
			if (state_q == sdlms_pkg::S_EDEC)
				tapres_q <= over_limit;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == sdlms_pkg::S_OUT && out_go)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == sdlms_pkg::S_OUT && out_go) begin
			eq_q  <= y;
			dec_q <= level;
			tr_q  <= tapres_q;
			ls_q  <= seg_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.equalized       = eq_q;
	assign out_ch.decision        = dec_q;
	assign out_ch.tap_reset       = tr_q;
	assign out_ch.last_of_segment = ls_q;

endmodule

FILE: design/sdlms_cell.sv
// One delay-line cell: a window sample, its flags and the matching tap.
// Uses sdlms_pkg for the control struct and the identity tap value.
module sdlms_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sdlms_pkg::cell_ctrl_t    ctrl,
	input  logic                     ident_one,
	input  logic signed [15:0]       nb_sample,
	input  logic [1:0]               nb_flags,
	input  logic signed [31:0]       nb_tap,
	output logic signed [15:0]       sample_q,
	output logic [1:0]               flags_q,
	output logic signed [31:0]       tap_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			flags_q  <= '0;
			tap_q    <= ident_one ? sdlms_pkg::ONE_Q27 : 32'sd0;
		end else if (ctrl.ident) begin
			tap_q <= ident_one ? sdlms_pkg::ONE_Q27 : 32'sd0;
		end else if (ctrl.rot) begin
			sample_q <= nb_sample;
			flags_q  <= nb_flags;
			tap_q    <= nb_tap;
		end else if (ctrl.shift) begin
			// window shift: samples move, taps stay in place
			sample_q <= nb_sample;
			flags_q  <= nb_flags;
		end
	end

endmodule

FILE: design/sdlms_head.sv
// Arithmetic at the head of the cell ring: MAC, slicer, step scaling,
// tap update and tap energy. Uses sdlms_pkg for widths and control struct.
module sdlms_head (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sdlms_pkg::head_ctrl_t    ctrl,
	input  logic signed [15:0]       x,
	input  logic signed [31:0]       tap,
	input  logic [31:0]              mu,
	input  logic [15:0]              ig,
	output logic signed [31:0]       tap_next,
	output logic signed [15:0]       y,
	output logic signed [3:0]        level,
	output logic                     adapt,
	output logic                     over_limit
);

	localparam int AW = sdlms_pkg::ACC_W;
	localparam int EW = sdlms_pkg::EN_W;
	localparam logic signed [AW-1:0] HALF27 = AW'(64'sd67108864);

	logic signed [47:0]    prod_s1;
	logic                  mac_s1;
	logic signed [AW-1:0]  acc_q;

	logic signed [AW-1:0]  acc_rnd;
	logic signed [AW-28:0] y_wide;
	logic signed [15:0]    y_c;
	logic signed [16:0]    ys17;
	logic [16:0]           ay;
	logic [1:0]            n_c;
	logic signed [3:0]     lvl_p;
	logic signed [3:0]     level_c;
	logic signed [13:0]    lv_sc;
	logic signed [16:0]    e_c;
	logic [16:0]           ae_c;
	logic [32:0]           prod_g;
	logic signed [33:0]    conf_c;

	logic signed [15:0]    y_q;
	logic signed [3:0]     level_q;
	logic signed [16:0]    e_q;
	logic signed [33:0]    conf_q;
	logic [31:0]           m_q;
	logic                  adapt_q;
	logic signed [39:0]    s_q;

	logic [54:0]           mc;
	logic                  conf_pos;
	logic signed [49:0]    me;
	logic signed [49:0]    me_r;
	logic signed [55:0]    sx;
	logic signed [55:0]    sx_r;
	logic signed [40:0]    d_c;
	logic signed [41:0]    t_c;
	logic signed [31:0]    t_sat;

	logic [31:0]           a_c;
	logic [63:0]           sq_c;
	logic [36:0]           sq_s1;
	logic                  sq_v_s1;
	logic [EW-1:0]         en_q;

	// FIR multiply-accumulate over the rotating ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1  <= 1'b0;
			sq_v_s1 <= 1'b0;
		end else begin
			mac_s1  <= ctrl.mac;
			sq_v_s1 <= ctrl.sq;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mac)
			prod_s1 <= x * tap;
		if (ctrl.acc_clr)
			acc_q <= '0;
		else if (mac_s1)
			acc_q <= acc_q + AW'(prod_s1);
	end

	// round half up to Q5.10, saturate, slice
	always_comb begin
		acc_rnd = acc_q + HALF27;
		y_wide  = acc_rnd[AW-1:27];
		if (y_wide > 32'sd32767)
			y_c = 16'sh7fff;
		else if (y_wide < -32'sd32768)
			y_c = -16'sh8000;
		else
			y_c = y_wide[15:0];
		ys17    = {y_c[15], y_c};
		ay      = y_c[15] ? 17'(-ys17) : 17'(ys17);
		n_c     = (ay[16:11] >= 6'd3) ? 2'd3 : ay[12:11];
		lvl_p   = {1'b0, n_c, 1'b1};
		level_c = y_c[15] ? -lvl_p : lvl_p;
		lv_sc   = {level_c, 10'd0};
		e_c     = ys17 - 17'(lv_sc);
		ae_c    = e_c[16] ? 17'(-e_c) : 17'(e_c);
		prod_g  = ae_c * ig;
		conf_c  = 34'sd4194304 - $signed({1'b0, prod_g});
	end

	always_comb begin
		conf_pos = !conf_q[33] && (conf_q != 34'sd0);
		mc       = mu * conf_q[22:0];
		me       = $signed({1'b0, m_q}) * e_q;
		me_r     = me + 50'sd512;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			adapt_q <= 1'b0;
		else if (ctrl.calc2)
			adapt_q <= (mu != 32'd0) && conf_pos;
	end

	always_ff @(posedge clk) begin
		if (ctrl.calc1) begin
			y_q     <= y_c;
			level_q <= level_c;
			e_q     <= e_c;
			conf_q  <= conf_c;
		end
		if (ctrl.calc2)
			m_q <= mc[53:22];
		if (ctrl.calc3)
			s_q <= me_r[49:10];
	end

	// tap update as the ring rotates past the head
	always_comb begin
		sx   = s_q * x;
		sx_r = sx + 56'sd16384;
		d_c  = sx_r[55:15];
		t_c  = 42'(tap) - 42'(d_c);
		if (t_c > 42'sd2147483647)
			t_sat = 32'sh7fffffff;
		else if (t_c < -42'sd2147483648)
			t_sat = -32'sh80000000;
		else
			t_sat = t_c[31:0];
		tap_next = ctrl.upd ? t_sat : tap;
	end

	// tap energy
	always_comb begin
		a_c  = tap[31] ? 32'(-tap) : 32'(tap);
		sq_c = a_c * a_c;
	end

	always_ff @(posedge clk) begin
		if (ctrl.sq)
			sq_s1 <= sq_c[63:27];
		if (ctrl.en_clr)
			en_q <= '0;
		else if (sq_v_s1)
			en_q <= en_q + EW'(sq_s1);
	end

	assign over_limit = en_q > sdlms_pkg::ENERGY_LIMIT;
	assign y          = y_q;
	assign level      = level_q;
	assign adapt      = adapt_q;

endmodule

FILE: design/sdlms_checker.sv
// Port-level checks on the equalizer result channel, bound to the top level.
// Depends on soft_decision_directed_lms_equalizer and sdlms_if.
module sdlms_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [15:0] equalized,
	input logic signed [3:0] decision,
	input logic              tap_reset,
	input logic              last_of_segment
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> decision[0] && (decision != -4'sd8))
		else $error("decision is not an odd level");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> equalized[15] == decision[3])
		else $error("decision sign differs from equalized sign");

	a_reset_seg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tap_reset |-> last_of_segment)
		else $error("tap reset outside segment end");

endmodule

bind soft_decision_directed_lms_equalizer sdlms_checker u_sdlms_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.equalized       (out_ch.equalized),
	.decision        (out_ch.decision),
	.tap_reset       (out_ch.tap_reset),
	.last_of_segment (out_ch.last_of_segment)
);
